[sv/cps_pkg.sv]
package cps_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_POINTS_DEF = 32;
  localparam int COORD_BITS_DEF = 16;

  // Fixed field widths on the streaming ports
  localparam int COORD_FIELD_W = 16;
  localparam int INDEX_FIELD_W = 5;
  localparam int IN_DATA_W     = 32;
  localparam int OUT_DATA_W    = 8;

  // Sequencer states
  localparam logic [3:0] ST_LOAD = 4'd0;
  localparam logic [3:0] ST_RDI  = 4'd1;
  localparam logic [3:0] ST_DI   = 4'd2;
  localparam logic [3:0] ST_SQI1 = 4'd3;
  localparam logic [3:0] ST_SQI2 = 4'd4;
  localparam logic [3:0] ST_RDJ  = 4'd5;
  localparam logic [3:0] ST_DJ   = 4'd6;
  localparam logic [3:0] ST_PJ   = 4'd7;
  localparam logic [3:0] ST_QJ   = 4'd8;
  localparam logic [3:0] ST_SQJ1 = 4'd9;
  localparam logic [3:0] ST_SQJ2 = 4'd10;
  localparam logic [3:0] ST_CMP  = 4'd11;
  localparam logic [3:0] ST_WR   = 4'd12;
  localparam logic [3:0] ST_ORD  = 4'd13;
  localparam logic [3:0] ST_CAP  = 4'd14;
  localparam logic [3:0] ST_OUT  = 4'd15;

endpackage

[sv/cps_ram.sv]
module cps_ram #(
  parameter int WIDTH = cps_pkg::COORD_BITS_DEF,
  parameter int DEPTH = cps_pkg::MAX_POINTS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/clockwise_point_sort_top.sv]
// Clockwise point sort.
// Input channel (in_*): one 2D point per transfer, x in tdata[15:0], y in
// tdata[31:16], tlast marks the final point of a set. Points are kept in a
// point RAM in arrival order while the count and the coordinate sums build up.
// Points past MAX_POINTS are dropped and the set is flagged as overflowed.
// After the tlast transfer the block ranks every point against every other:
// for each point i it streams all points j through one compare sequencer
// (states RDJ, DJ, PJ, QJ, SQJ1, SQJ2 and CMP per pair, set by the shared
// point RAM port and the multiply steps; each point i adds RDI, DI, SQI1,
// SQI2 and WR). Ranks go into an order RAM.
// Output channel (out_*): one point index per transfer in clockwise order
// around the centroid, tlast on the final index, tuser set on every index of
// an overflowed set. Each index passes ORD and CAP and waits in OUT; a stalled
// receiver simply holds the block. in_tready is low from the tlast transfer
// until the last index has been taken; the set is then cleared.
// Reset clears the count, the sums, the flag and the sequencer; the RAMs are
// not cleared.
module clockwise_point_sort_top #(
  parameter int MAX_POINTS = cps_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = cps_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [cps_pkg::IN_DATA_W-1:0]  in_tdata,   // point_x, point_y
  input  logic                           in_tlast,   // last_point
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [cps_pkg::OUT_DATA_W-1:0] out_tdata,  // point_index, zero pad
  output logic                           out_tlast,  // last_index
  output logic                           out_tuser   // overflowed
);

  localparam int CW    = COORD_BITS;
  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int SUM_W = CW + CNT_W;
  localparam int D_W   = CW + CNT_W + 1;
  localparam int P_W   = 2 * D_W;
  localparam int S_W   = 2 * D_W + 1;
  localparam int FW    = cps_pkg::COORD_FIELD_W;

  logic [3:0] state_r, state_nxt;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] i_r, i_nxt, j_r, j_nxt, rank_r, rank_nxt, k_r, k_nxt;
  logic signed [SUM_W-1:0] sum_x_r, sum_x_nxt, sum_y_r, sum_y_nxt;
  logic drop_r, drop_nxt;

  logic signed [D_W-1:0] dxi_r, dxi_nxt, dyi_r, dyi_nxt;
  logic signed [D_W-1:0] dxj_r, dxj_nxt, dyj_r, dyj_nxt;
  logic signed [P_W-1:0] p_r, p_nxt, q_r, q_nxt, sq_r, sq_nxt;
  logic signed [S_W-1:0] dsi_r, dsi_nxt, dsj_r, dsj_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [cps_pkg::INDEX_FIELD_W-1:0] out_idx_r, out_idx_nxt;
  logic                         out_last_r, out_last_nxt;
  logic                         out_ovf_r, out_ovf_nxt;

  // point RAM
  logic              pt_we;
  logic [IDX_W-1:0]  pt_waddr, pt_raddr;
  logic [2*CW-1:0]   pt_wdata, pt_rdata;
  // order RAM
  logic              ord_we;
  logic [IDX_W-1:0]  ord_waddr, ord_raddr;
  logic [IDX_W-1:0]  ord_wdata, ord_rdata;

  logic [CW-1:0] in_x, in_y;
  logic          in_fire, full;
  logic signed [D_W-1:0] ram_x, ram_y, n_s, dx_new, dy_new;
  logic          j_first;

  assign in_x    = CW'(in_tdata[FW-1:0]);
  assign in_y    = CW'(in_tdata[2*FW-1:FW]);
  assign in_fire = in_tvalid && in_tready;
  assign full    = (cnt_r == CNT_W'(MAX_POINTS));

  assign in_tready  = (state_r == cps_pkg::ST_LOAD);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = cps_pkg::OUT_DATA_W'(out_idx_r);
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

  assign pt_we    = in_fire && !full;
  assign pt_waddr = cnt_r[IDX_W-1:0];
  assign pt_wdata = {in_y, in_x};
  assign pt_raddr = (state_r == cps_pkg::ST_RDI) ? i_r[IDX_W-1:0] : j_r[IDX_W-1:0];

  assign ord_we    = (state_r == cps_pkg::ST_WR);
  assign ord_waddr = rank_r[IDX_W-1:0];
  assign ord_wdata = i_r[IDX_W-1:0];
  assign ord_raddr = k_r[IDX_W-1:0];

  cps_ram #(.WIDTH(2 * CW), .DEPTH(MAX_POINTS)) u_pt_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata (pt_wdata),
    .raddr (pt_raddr),
    .rdata (pt_rdata)
  );

  cps_ram #(.WIDTH(IDX_W), .DEPTH(MAX_POINTS)) u_ord_ram (
    .clk   (clk),
    .we    (ord_we),
    .waddr (ord_waddr),
    .wdata (ord_wdata),
    .raddr (ord_raddr),
    .rdata (ord_rdata)
  );

  // Centroid offsets scaled by the count
  assign ram_x  = D_W'($signed(pt_rdata[CW-1:0]));
  assign ram_y  = D_W'($signed(pt_rdata[2*CW-1:CW]));
  assign n_s    = $signed(D_W'(cnt_r));
  assign dx_new = n_s * ram_x - D_W'(sum_x_r);
  assign dy_new = n_s * ram_y - D_W'(sum_y_r);

  // Does point j go before point i
  always_comb begin
    j_first = 1'b0;
    if (dxj_r >= 0 && dxi_r < 0) begin
      j_first = 1'b1;
    end else if (dxj_r < 0 && dxi_r >= 0) begin
      j_first = 1'b0;
    end else if (dxj_r == 0 && dxi_r == 0) begin
      if (dyj_r != dyi_r) begin
        if (dyj_r >= 0 || dyi_r >= 0) begin
          j_first = (dyj_r > dyi_r);
        end else begin
          j_first = (dyi_r > dyj_r);
        end
      end else begin
        j_first = (j_r < i_r);
      end
    end else if (p_r != q_r) begin
      j_first = (p_r < q_r);
    end else if (dsj_r != dsi_r) begin
      j_first = (dsj_r > dsi_r);
    end else begin
      j_first = (j_r < i_r);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sum_x_nxt     = sum_x_r;
    sum_y_nxt     = sum_y_r;
    drop_nxt      = drop_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    rank_nxt      = rank_r;
    k_nxt         = k_r;
    dxi_nxt       = dxi_r;
    dyi_nxt       = dyi_r;
    dxj_nxt       = dxj_r;
    dyj_nxt       = dyj_r;
    p_nxt         = p_r;
    q_nxt         = q_r;
    sq_nxt        = sq_r;
    dsi_nxt       = dsi_r;
    dsj_nxt       = dsj_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;

    unique case (state_r)
      cps_pkg::ST_LOAD: begin
        if (in_fire) begin
          if (full) begin
            drop_nxt = 1'b1;
          end else begin
            cnt_nxt   = cnt_r + 1'b1;
            sum_x_nxt = sum_x_r + SUM_W'($signed(in_x));
            sum_y_nxt = sum_y_r + SUM_W'($signed(in_y));
          end
          if (in_tlast) begin
            i_nxt     = '0;
            state_nxt = cps_pkg::ST_RDI;
          end
        end
      end
      cps_pkg::ST_RDI: state_nxt = cps_pkg::ST_DI;
      cps_pkg::ST_DI: begin
        dxi_nxt   = dx_new;
        dyi_nxt   = dy_new;
        state_nxt = cps_pkg::ST_SQI1;
      end
      cps_pkg::ST_SQI1: begin
        sq_nxt    = dxi_r * dxi_r;
        state_nxt = cps_pkg::ST_SQI2;
      end
      cps_pkg::ST_SQI2: begin
        dsi_nxt   = S_W'(sq_r) + S_W'(P_W'(dyi_r) * P_W'(dyi_r));
        j_nxt     = '0;
        rank_nxt  = '0;
        state_nxt = cps_pkg::ST_RDJ;
      end
      cps_pkg::ST_RDJ: state_nxt = cps_pkg::ST_DJ;
      cps_pkg::ST_DJ: begin
        dxj_nxt   = dx_new;
        dyj_nxt   = dy_new;
        state_nxt = cps_pkg::ST_PJ;
      end
      cps_pkg::ST_PJ: begin
        p_nxt     = dxj_r * dyi_r;
        state_nxt = cps_pkg::ST_QJ;
      end
      cps_pkg::ST_QJ: begin
        q_nxt     = dxi_r * dyj_r;
        state_nxt = cps_pkg::ST_SQJ1;
      end
      cps_pkg::ST_SQJ1: begin
        sq_nxt    = dxj_r * dxj_r;
        state_nxt = cps_pkg::ST_SQJ2;
      end
      cps_pkg::ST_SQJ2: begin
        dsj_nxt   = S_W'(sq_r) + S_W'(P_W'(dyj_r) * P_W'(dyj_r));
        state_nxt = cps_pkg::ST_CMP;
      end
      cps_pkg::ST_CMP: begin
        if (j_first) begin
          rank_nxt = rank_r + 1'b1;
        end
        if (j_r == cnt_r - 1'b1) begin
          state_nxt = cps_pkg::ST_WR;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = cps_pkg::ST_RDJ;
        end
      end
      cps_pkg::ST_WR: begin
        if (i_r == cnt_r - 1'b1) begin
          k_nxt     = '0;
          state_nxt = cps_pkg::ST_ORD;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = cps_pkg::ST_RDI;
        end
      end
      cps_pkg::ST_ORD: state_nxt = cps_pkg::ST_CAP;
      cps_pkg::ST_CAP: begin
        out_valid_nxt = 1'b1;
        out_idx_nxt   = cps_pkg::INDEX_FIELD_W'(ord_rdata);
        out_last_nxt  = (k_r == cnt_r - 1'b1);
        out_ovf_nxt   = drop_r;
        state_nxt     = cps_pkg::ST_OUT;
      end
      cps_pkg::ST_OUT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            // clear the set
            cnt_nxt   = '0;
            sum_x_nxt = '0;
            sum_y_nxt = '0;
            drop_nxt  = 1'b0;
            state_nxt = cps_pkg::ST_LOAD;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = cps_pkg::ST_ORD;
          end
        end
      end
      default: state_nxt = cps_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cps_pkg::ST_LOAD;
      cnt_r       <= '0;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      rank_r      <= '0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sum_x_r     <= sum_x_nxt;
      sum_y_r     <= sum_y_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      rank_r      <= rank_nxt;
      k_r         <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dxi_r      <= dxi_nxt;
    dyi_r      <= dyi_nxt;
    dxj_r      <= dxj_nxt;
    dyj_r      <= dyj_nxt;
    p_r        <= p_nxt;
    q_r        <= q_nxt;
    sq_r       <= sq_nxt;
    dsi_r      <= dsi_nxt;
    dsj_r      <= dsj_nxt;
    out_idx_r  <= out_idx_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

endmodule

[verif/tb_clockwise_point_sort_top.sv]
`timescale 1ns / 1ps

module tb_clockwise_point_sort_top;

  localparam int NPTS          = cps_pkg::MAX_POINTS_DEF;
  localparam int INDEX_FIELD_W = cps_pkg::INDEX_FIELD_W;
  localparam int COORD_FIELD_W = cps_pkg::COORD_FIELD_W;
  localparam int IN_DATA_W     = cps_pkg::IN_DATA_W;
  localparam int OUT_DATA_W    = cps_pkg::OUT_DATA_W;
  localparam int WDOG_LIMIT    = 200000;

  typedef struct packed {
    logic [INDEX_FIELD_W-1:0] idx;
    logic                     last;
    logic                     ovf;
  } sorted_idx_t;

  typedef struct {
    logic signed [COORD_FIELD_W-1:0] x;
    logic signed [COORD_FIELD_W-1:0] y;
    logic                            last;
    logic                            has_exp;
    logic [INDEX_FIELD_W-1:0]        exp_idx;
  } point_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  out_tuser;

  // predictor state
  longint      pt_x [NPTS];
  longint      pt_y [NPTS];
  int          pt_cnt;
  longint      sx, sy;
  bit          dropped;
  sorted_idx_t sorted_q[$];
  int          fixed_idx_q[$];   // -1 when no typed-in value
  int          errors;
  bit          hold_off;
  int          idle_cycles;
  point_row_t  dir_rows[$];

  always #5 clk = ~clk;

  clockwise_point_sort_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser)
  );

  function automatic bit cw_precedes(int a, int b);
    longint n, ax, ay, bx, by, p, q, da, db;
    n  = pt_cnt;
    ax = n * pt_x[a] - sx;  ay = n * pt_y[a] - sy;
    bx = n * pt_x[b] - sx;  by = n * pt_y[b] - sy;
    if (ax >= 0 && bx < 0) return 1'b1;
    if (ax < 0 && bx >= 0) return 1'b0;
    if (ax == 0 && bx == 0) begin
      if (ay != by) begin
        if (ay >= 0 || by >= 0) return ay > by;
        return by > ay;
      end
      return a < b;
    end
    p = ax * by;
    q = bx * ay;
    if (p < q) return 1'b1;
    if (p > q) return 1'b0;
    da = ax * ax + ay * ay;
    db = bx * bx + by * by;
    if (da != db) return da > db;
    return a < b;
  endfunction

  task automatic add_point(logic signed [15:0] x, logic signed [15:0] y, logic last,
                           int fixed_first);
    int ord[NPTS];
    int i, j, v;
    sorted_idx_t r;
    if (pt_cnt < NPTS) begin
      pt_x[pt_cnt] = x;
      pt_y[pt_cnt] = y;
      sx += x;
      sy += y;
      pt_cnt++;
    end else begin
      dropped = 1'b1;
    end
    if (!last) return;
    for (i = 0; i < pt_cnt; i++) begin
      v = i;
      j = i;
      while (j > 0 && cw_precedes(v, ord[j-1])) begin
        ord[j] = ord[j-1];
        j--;
      end
      ord[j] = v;
    end
    for (i = 0; i < pt_cnt; i++) begin
      r.idx  = ord[i][INDEX_FIELD_W-1:0];
      r.last = (i == pt_cnt - 1);
      r.ovf  = dropped;
      sorted_q.insert(sorted_q.size(), r);
      fixed_idx_q.insert(fixed_idx_q.size(), (i == 0) ? fixed_first : -1);
    end
    pt_cnt  = 0;
    sx      = 0;
    sy      = 0;
    dropped = 1'b0;
  endtask

  task automatic send_point(logic signed [15:0] x, logic signed [15:0] y, logic last,
                            int fixed_first);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {y, x};
    in_tlast  <= last;
    add_point(x, y, last, fixed_first);
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic signed [15:0] rand_coord(int mode);
    case (mode)
      0:       return 16'($urandom_range(0, 65535));
      1:       return $signed(16'($urandom_range(0, 8))) - 16'sd4;
      default: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    endcase
  endfunction

  // receiver: random stalls plus one long hold-off
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off) out_tready <= 1'b0;
      else if ($urandom_range(0, 19) == 0) out_tready <= 1'b0;
      else if ($urandom_range(0, 3) == 0) out_tready <= ~out_tready;
      else out_tready <= 1'b1;
    end
  end

  // checker
  always @(posedge clk) begin
    sorted_idx_t e;
    int fx;
    if (rst_n && out_tvalid && out_tready) begin
      if (sorted_q.size() == 0) begin
        $display("%0t: unexpected index %0d", $time, out_tdata[INDEX_FIELD_W-1:0]);
        errors++;
      end else begin
        e  = sorted_q.pop_front();
        fx = fixed_idx_q.pop_front();
        if (fx >= 0 && e.idx != fx) begin
          $display("%0t: predictor index exp %0d act %0d", $time, fx, e.idx);
          errors++;
        end
        if (out_tdata[INDEX_FIELD_W-1:0] != e.idx) begin
          $display("%0t: index exp %0d act %0d", $time, e.idx,
                   out_tdata[INDEX_FIELD_W-1:0]);
          errors++;
        end
        if (out_tdata[OUT_DATA_W-1:INDEX_FIELD_W] != '0) begin
          $display("%0t: pad exp 0 act %0h", $time, out_tdata[OUT_DATA_W-1:INDEX_FIELD_W]);
          errors++;
        end
        if (out_tlast != e.last) begin
          $display("%0t: tlast exp %0b act %0b", $time, e.last, out_tlast);
          errors++;
        end
        if (out_tuser != e.ovf) begin
          $display("%0t: tuser exp %0b act %0b", $time, e.ovf, out_tuser);
          errors++;
        end
      end
    end
  end

  // watchdog
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("clockwise_point_sort_top verification failed");
        $finish;
      end
    end
  end

  initial begin
    int n, k, mode, settle;
    point_row_t r;
    errors = 0; pt_cnt = 0; sx = 0; sy = 0; dropped = 0; hold_off = 0;
    // directed: single point, two points, axis cases, duplicates, extremes
    dir_rows = '{
      '{16'sh0000, 16'sh0000, 1'b1, 1'b1, 5'd0},
      '{16'sh7fff, 16'sh7fff, 1'b0, 1'b0, 5'd0},
      '{16'sh8000, 16'sh8000, 1'b1, 1'b1, 5'd0},
      '{16'sh0000, 16'sh0005, 1'b0, 1'b0, 5'd0},
      '{16'sh0000, -16'sh0005, 1'b0, 1'b0, 5'd0},
      '{16'sh0005, 16'sh0000, 1'b0, 1'b0, 5'd0},
      '{-16'sh0005, 16'sh0000, 1'b1, 1'b1, 5'd0},
      '{16'sh0002, 16'sh0002, 1'b0, 1'b0, 5'd0},
      '{16'sh0004, 16'sh0004, 1'b0, 1'b0, 5'd0},
      '{16'sh0002, 16'sh0002, 1'b0, 1'b0, 5'd0},
      '{-16'sh0008, -16'sh0008, 1'b1, 1'b0, 5'd0},
      '{16'sh7fff, 16'sh8000, 1'b0, 1'b0, 5'd0},
      '{16'sh8000, 16'sh7fff, 1'b1, 1'b0, 5'd0}
    };
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      send_point(r.x, r.y, r.last, r.has_exp ? int'(r.exp_idx) : -1);
    end
    // full store: 34 points, last one dropped too
    for (k = 0; k < NPTS + 2; k++)
      send_point(rand_coord(0), rand_coord(0), k == NPTS + 1, -1);

    // long receiver hold-off while a set is loaded and sorted
    hold_off = 1'b1;
    fork
      begin repeat (3000) @(posedge clk); hold_off = 1'b0; end
      begin
        for (k = 0; k < 6; k++) send_point(rand_coord(1), rand_coord(1), k == 5, -1);
        for (k = 0; k < 3; k++) send_point(rand_coord(1), rand_coord(1), k == 2, -1);
      end
    join

    // random sets, mostly small
    k = 0;
    while (k < 264) begin
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, NPTS + 3) : $urandom_range(1, 8);
      mode = $urandom_range(0, 2);
      for (int j = 0; j < n; j++) begin
        send_point(rand_coord(mode == 2 ? $urandom_range(0, 2) : mode),
                   rand_coord(mode == 2 ? $urandom_range(0, 2) : mode), j == n - 1, -1);
        k++;
      end
    end
    in_tvalid <= 1'b0;

    settle = 0;
    while (sorted_q.size() != 0 && settle < 1000000) begin
      @(posedge clk);
      settle++;
    end
    repeat (50) @(posedge clk);
    if (errors == 0 && sorted_q.size() == 0) begin
      $display("clockwise_point_sort_top verification clean");
    end else begin
      if (sorted_q.size() != 0)
        $display("%0t: %0d indices never arrived", $time, sorted_q.size());
      $display("clockwise_point_sort_top verification failed");
    end
    $finish;
  end

endmodule
